FILE: rtl/bdd_pkg.sv
// Shared types and constants for the BCD digit display driver.
package bdd_pkg;

  localparam int VALUE_W = 32;
  localparam int DIGIT_W = 4;
  localparam int CNT_W   = 4;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [DIGIT_W-1:0] digit_t;
  typedef logic [CNT_W-1:0]   count_t;

  // Digit count after reset
  localparam count_t DIGIT_COUNT_RESET = 4'd3;

  // Divide by ten: floor(q * RECIP_TEN / 2^RECIP_SHIFT) is exact for any 32-bit q
  localparam logic [32:0] RECIP_TEN   = 33'h0_CCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;
  localparam int          PROD_W      = VALUE_W + 33;

endpackage

FILE: rtl/bdd_if.sv
// Valid/ready channel interfaces for values in and digits out.
interface bdd_in_if;
  import bdd_pkg::*;
  logic   valid;
  logic   ready;
  value_t value;
  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface bdd_out_if;
  import bdd_pkg::*;
  logic   valid;
  logic   ready;
  digit_t bcd_digit;
  count_t digit_select;
  logic   last_digit;
  modport source (output valid, output bcd_digit, output digit_select,
                  output last_digit, input ready);
  modport sink   (input valid, input bcd_digit, input digit_select,
                  input last_digit, output ready);
endinterface

FILE: rtl/bdd_cell.sv
// One divide-by-ten cell: peels off the low decimal digit and passes the quotient on.
module bdd_cell #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  bdd_pkg::value_t                        in_quot,
  input  logic [MAX_DIGITS-1:0][bdd_pkg::DIGIT_W-1:0] in_digs,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output bdd_pkg::value_t                        out_quot,
  output logic [MAX_DIGITS-1:0][bdd_pkg::DIGIT_W-1:0] out_digs
);
  import bdd_pkg::*;

  localparam int DIGS_W = MAX_DIGITS * DIGIT_W;

  logic [PROD_W-1:0]         prod;
  value_t                    quot;
  value_t                    tens;
  digit_t                    rem;
  logic [DIGS_W+DIGIT_W-1:0] digs_cat;

  // Quotient by reciprocal multiply, remainder by shift-add back-multiply
  always_comb begin
    prod     = PROD_W'(in_quot) * PROD_W'(RECIP_TEN);
    quot     = VALUE_W'(prod[PROD_W-1:RECIP_SHIFT]);
    tens     = (quot << 3) + (quot << 1);
    rem      = DIGIT_W'(in_quot - tens);
    digs_cat = {rem, in_digs};
  end

  // Stage advances when empty or when downstream takes its item
  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  // New digit enters at the top; older digits move down one slot
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      out_quot <= quot;
      out_digs <= digs_cat[DIGS_W+DIGIT_W-1:DIGIT_W];
    end
  end

endmodule

FILE: rtl/bdd_serial.sv
// Output stage: holds one value's digits and emits them most significant first.
module bdd_serial #(
  parameter int MAX_DIGITS = 10
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  bdd_pkg::count_t                        eff_count,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [MAX_DIGITS-1:0][bdd_pkg::DIGIT_W-1:0] in_digs,
  bdd_out_if.source                              result
);
  import bdd_pkg::*;

  logic                              busy;
  count_t                            ptr;
  count_t                            sel;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] sh;
  logic                              emit;
  logic                              done;
  logic                              load;
  digit_t                            cur_digit;

  assign emit     = busy && result.ready;
  assign done     = emit && (ptr == '0);
  assign in_ready = !busy || done;
  assign load     = in_valid && in_ready;

  // Busy while a run is pending; a zero count drops the value
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (load) begin
      busy <= (eff_count != '0);
    end else if (done) begin
      busy <= 1'b0;
    end
  end

  // ptr walks from the top digit down, sel counts select lines up
  always_ff @(posedge clk) begin
    if (load) begin
      sh  <= in_digs;
      ptr <= eff_count - 4'd1;
      sel <= '0;
    end else if (emit) begin
      ptr <= ptr - 4'd1;
      sel <= sel + 4'd1;
    end
  end

  // Digit pick
  always_comb begin
    cur_digit = '0;
    for (int j = 0; j < MAX_DIGITS; j++) begin
      if (ptr == CNT_W'(j)) cur_digit = sh[j];
    end
  end

  assign result.valid        = busy;
  assign result.bcd_digit    = cur_digit;
  assign result.digit_select = sel;
  assign result.last_digit   = (ptr == '0);

endmodule

FILE: rtl/bcd_digit_display_driver_core.sv
// Top level: binary to BCD conversion through a chain of divide-by-ten cells.
// Each 32-bit value is accepted on the data channel and flows through
// MAX_DIGITS divide-by-ten cells, each cell splitting off the next decimal
// digit; the output stage then sends one result per digit, most significant
// first, at one digit per cycle while result.ready is high. The cells form a
// pipeline and the output stage takes the next value as the last digit of a
// run is taken; a value with a digit count of zero produces nothing. Digits
// are those of value modulo 10^count, with leading zeros; digit_select is 0
// on the most significant digit and last_digit marks the end of each run.
// digit_count (reset 3) is written through cfg_we/cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
// Counts above MAX_DIGITS saturate to MAX_DIGITS.
module bcd_digit_display_driver_core #(
  parameter int MAX_DIGITS = 10
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  bdd_pkg::count_t cfg_wdata,
  bdd_in_if.sink          data,
  bdd_out_if.source       result
);
  import bdd_pkg::*;

  count_t digit_count;
  count_t eff_count;

  logic                               vld  [0:MAX_DIGITS];
  logic                               rdy  [0:MAX_DIGITS];
  value_t                             quot [0:MAX_DIGITS];
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0] digs [0:MAX_DIGITS];

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      digit_count <= DIGIT_COUNT_RESET;
    end else if (cfg_we) begin
      digit_count <= cfg_wdata;
    end
  end

  // Saturate to the number of select lines
  always_comb begin
    if (digit_count > CNT_W'(MAX_DIGITS)) begin
      eff_count = CNT_W'(MAX_DIGITS);
    end else begin
      eff_count = digit_count;
    end
  end

  // Chain head
  assign vld[0]     = data.valid;
  assign data.ready = rdy[0];
  assign quot[0]    = data.value;
  assign digs[0]    = '0;

  for (genvar k = 0; k < MAX_DIGITS; k++) begin : g_cell
    bdd_cell #(
      .MAX_DIGITS (MAX_DIGITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_quot   (quot[k]),
      .in_digs   (digs[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_quot  (quot[k+1]),
      .out_digs  (digs[k+1])
    );
  end

  bdd_serial #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_serial (
    .clk       (clk),
    .rst       (rst),
    .eff_count (eff_count),
    .in_valid  (vld[MAX_DIGITS]),
    .in_ready  (rdy[MAX_DIGITS]),
    .in_digs   (digs[MAX_DIGITS]),
    .result    (result)
  );

endmodule

FILE: rtl/bdd_checker.sv
// Port-level checks on the digit output stream, bound to the top level.
module bdd_checker (
  input logic            clk,
  input logic            rst,
  input logic            result_valid,
  input logic            result_ready,
  input bdd_pkg::digit_t result_bcd_digit,
  input bdd_pkg::count_t result_digit_select,
  input logic            result_last_digit
);
  import bdd_pkg::*;

  // Nothing is offered right after reset
  a_reset_idle: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid right after reset");

  // Only decimal digits leave the block
  a_bcd_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_bcd_digit <= 4'd9))
    else $error("bcd digit out of range");

  // A run continues on the next select line after a non-final transfer
  a_run_next: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && !result_last_digit) |=>
      (result_valid && (result_digit_select == $past(result_digit_select) + 4'd1)))
    else $error("digit run broken or select line skipped");

  // A new run starts on the most significant select line
  a_run_start: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result_last_digit) |=>
      (!result_valid || (result_digit_select == '0)))
    else $error("new run does not start at select line zero");

endmodule

bind bcd_digit_display_driver_core bdd_checker u_bdd_checker (
  .clk                 (clk),
  .rst                 (rst),
  .result_valid        (result.valid),
  .result_ready        (result.ready),
  .result_bcd_digit    (result.bcd_digit),
  .result_digit_select (result.digit_select),
  .result_last_digit   (result.last_digit)
);
